@@ hw/rtl/sha1_pkg.sv @@
package sha1_pkg;

    // working variables of the compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_work;

    // initial chaining words
    localparam logic [31:0] H_INIT0 = 32'h67452301;
    localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
    localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
    localparam logic [31:0] H_INIT3 = 32'h10325476;
    localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K_ROUND0 = 32'h5A827999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

    localparam int          ROUNDS     = 80;
    localparam int          RND_W      = 7;
    localparam int          GROUP_LEN  = 20;
    localparam int          LEN_POS    = 56;
    localparam logic [7:0]  PAD_MARK   = 8'h80;

endpackage

@@ hw/rtl/sha1_round.sv @@
module sha1_round (
    input  sha1_pkg::t_work                i_work,
    input  logic [31:0]                    i_w,
    input  logic [sha1_pkg::RND_W-1:0]     i_rnd,
    output sha1_pkg::t_work                o_work
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] rot_a;
    logic [31:0] temp;

    // boolean function and constant by round group
    always_comb begin
        if (i_rnd < sha1_pkg::RND_W'(sha1_pkg::GROUP_LEN)) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = sha1_pkg::K_ROUND0;
        end else if (i_rnd < sha1_pkg::RND_W'(2 * sha1_pkg::GROUP_LEN)) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1_pkg::K_ROUND1;
        end else if (i_rnd < sha1_pkg::RND_W'(3 * sha1_pkg::GROUP_LEN)) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = sha1_pkg::K_ROUND2;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1_pkg::K_ROUND3;
        end
    end

    // one round step
    assign rot_a = {i_work.a[26:0], i_work.a[31:27]};
    assign temp  = rot_a + f + i_work.e + i_w + k;

    always_comb begin
        o_work.a = temp;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

@@ hw/rtl/sha1_hash_engine.sv @@
// SHA-1 hash engine.
// Input stream: each word carries one request. s_axis_tuser is the request
// kind (0 absorb the byte in s_axis_tdata, 1 finish the message). Absorbed
// bytes are collected into a 64-byte block; a finish pads the message and
// returns the digest.
// Output stream: five words, H0 first, m_axis_tlast on H4. m_axis_tuser
// gives the word index and the sticky length overflow flag.
// Sequence: an absorb is taken while idle; the byte that completes a block
// starts the 80 rounds on the single shared round unit, then the chaining
// add. A finish shifts in the padding one byte per cycle (up to 64 bytes,
// or up to 72 when a second block is needed), runs one or two compressions
// and then presents the digest words, one per accepted output word.
// s_axis_tready is high only while the engine waits for a request.
// The digest waits as long as the receiver stalls; nothing new is taken.
// After the fifth word the engine is back in its initial state.
// Synchronous active-low reset loads the initial hash values and clears
// the byte position, bit count and overflow flag.
module sha1_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [3:0]  m_axis_tuser,   // [2:0] word_index, [3] length_overflow
    output logic        m_axis_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    localparam logic REQ_ABSORB = 1'b0;
    localparam logic REQ_FINISH = 1'b1;

    localparam logic [2:0] LAST_IDX = 3'd4;

    logic [2:0]                      r_state;
    logic [511:0]                    r_buf;
    logic [5:0]                      r_pos;
    logic [63:0]                     r_len;
    logic                            r_ovf;
    logic                            r_fin;
    logic                            r_mark;
    logic                            r_len_ok;
    logic [sha1_pkg::RND_W-1:0]      r_rnd;
    sha1_pkg::t_work                 r_work;
    logic [31:0]                     r_chain [5];
    logic [2:0]                      r_widx;

    sha1_pkg::t_work                 round_out;
    sha1_pkg::t_work                 chain_work;
    logic [31:0]                     sched_w;
    logic [64:0]                     len_sum;
    logic [63:0]                     len_sh;
    logic [7:0]                      pad_byte;
    logic                            in_acc;
    logic                            out_acc;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign out_acc       = m_axis_tvalid && m_axis_tready;

    // digest word output
    assign m_axis_tdata = r_chain[r_widx];
    assign m_axis_tuser = {r_ovf, r_widx};
    assign m_axis_tlast = (r_widx == LAST_IDX);

    // shared round unit
    sha1_round u_round (
        .i_work (r_work),
        .i_w    (r_buf[511:480]),
        .i_rnd  (r_rnd),
        .o_work (round_out)
    );

    // message schedule: next word from the 16-word window
    always_comb begin
        logic [31:0] x;
        x       = r_buf[511:480] ^ r_buf[447:416] ^ r_buf[255:224] ^ r_buf[95:64];
        sched_w = {x[30:0], x[31]};
    end

    // bit count with carry out
    assign len_sum = {1'b0, r_len} + 65'd8;

    // padding byte: marker, zeros or big-endian length
    assign len_sh = r_len >> {~r_pos[2:0], 3'b000};
    always_comb begin
        if (!r_mark) begin
            pad_byte = sha1_pkg::PAD_MARK;
        end else if (r_len_ok && (r_pos >= 6'(sha1_pkg::LEN_POS))) begin
            pad_byte = len_sh[7:0];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // current chaining words as working variables
    always_comb begin
        chain_work.a = r_chain[0];
        chain_work.b = r_chain[1];
        chain_work.c = r_chain[2];
        chain_work.d = r_chain[3];
        chain_work.e = r_chain[4];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_len      <= '0;
            r_ovf      <= 1'b0;
            r_fin      <= 1'b0;
            r_mark     <= 1'b0;
            r_len_ok   <= 1'b0;
            r_rnd      <= '0;
            r_widx     <= '0;
            r_chain[0] <= sha1_pkg::H_INIT0;
            r_chain[1] <= sha1_pkg::H_INIT1;
            r_chain[2] <= sha1_pkg::H_INIT2;
            r_chain[3] <= sha1_pkg::H_INIT3;
            r_chain[4] <= sha1_pkg::H_INIT4;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser == REQ_ABSORB) begin
                            r_buf <= {r_buf[503:0], s_axis_tdata};
                            r_pos <= r_pos + 6'd1;
                            r_len <= len_sum[63:0];
                            if (len_sum[64]) begin
                                r_ovf <= 1'b1;
                            end
                            if (r_pos == 6'd63) begin
                                r_work  <= chain_work;
                                r_rnd   <= '0;
                                r_state <= ST_ROUND;
                            end
                        end else if (s_axis_tuser == REQ_FINISH) begin
                            r_fin   <= 1'b1;
                            r_mark  <= 1'b0;
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    r_buf <= {r_buf[503:0], pad_byte};
                    r_pos <= r_pos + 6'd1;
                    if (!r_mark) begin
                        r_mark   <= 1'b1;
                        r_len_ok <= (r_pos < 6'(sha1_pkg::LEN_POS));
                    end
                    if (r_pos == 6'd63) begin
                        r_work  <= chain_work;
                        r_rnd   <= '0;
                        r_state <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    r_work <= round_out;
                    r_buf  <= {r_buf[479:0], sched_w};
                    r_rnd  <= r_rnd + 1'b1;
                    if (r_rnd == sha1_pkg::RND_W'(sha1_pkg::ROUNDS - 1)) begin
                        r_state <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    r_chain[0] <= r_chain[0] + r_work.a;
                    r_chain[1] <= r_chain[1] + r_work.b;
                    r_chain[2] <= r_chain[2] + r_work.c;
                    r_chain[3] <= r_chain[3] + r_work.d;
                    r_chain[4] <= r_chain[4] + r_work.e;
                    if (!r_fin) begin
                        r_state <= ST_IDLE;
                    end else if (r_len_ok) begin
                        r_widx  <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        // length did not fit, pad a second block
                        r_len_ok <= 1'b1;
                        r_state  <= ST_PAD;
                    end
                end
                ST_EMIT: begin
                    if (out_acc) begin
                        if (r_widx == LAST_IDX) begin
                            // back to the initial state for a new message
                            r_chain[0] <= sha1_pkg::H_INIT0;
                            r_chain[1] <= sha1_pkg::H_INIT1;
                            r_chain[2] <= sha1_pkg::H_INIT2;
                            r_chain[3] <= sha1_pkg::H_INIT3;
                            r_chain[4] <= sha1_pkg::H_INIT4;
                            r_pos      <= '0;
                            r_len      <= '0;
                            r_ovf      <= 1'b0;
                            r_fin      <= 1'b0;
                            r_len_ok   <= 1'b0;
                            r_widx     <= '0;
                            r_state    <= ST_IDLE;
                        end else begin
                            r_widx <= r_widx + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
